// ===== hdl/flag_setting_alu_barrel_shift_core_defines.svh =====
// Assertion macros used by the checker file.
// Each macro expects clk and arst_n in scope.
`ifndef FLAG_SETTING_ALU_BARREL_SHIFT_CORE_DEFINES_SVH
`define FLAG_SETTING_ALU_BARREL_SHIFT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSAB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fsab: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FSAB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fsab: next-cycle check failed");

`endif

// ===== hdl/fsab_pkg.sv =====
package fsab_pkg;

	localparam int DATA_W      = 32;
	localparam int AMT_W       = 8;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_LSL = 4'd2,
		OP_LSR = 4'd3,
		OP_ASR = 4'd4,
		OP_ADC = 4'd5,
		OP_SBC = 4'd6,
		OP_ROR = 4'd7,
		OP_TST = 4'd8,
		OP_NEG = 4'd9,
		OP_CMP = 4'd10,
		OP_CMN = 4'd11,
		OP_ORR = 4'd12,
		OP_MUL = 4'd13,
		OP_BIC = 4'd14,
		OP_MVN = 4'd15
	} alu_op_t;

	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} flags_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              carry;
	} shift_res_t;

	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic              write_back;
		flags_t            flags;
	} alu_res_t;

endpackage

// ===== hdl/fsab_shift.sv =====
module fsab_shift (
	input  fsab_pkg::alu_op_t             op,
	input  logic [fsab_pkg::DATA_W-1:0]   value,
	input  logic [fsab_pkg::AMT_W-1:0]    amt,
	input  logic                          carry_in,
	output fsab_pkg::shift_res_t          res
);
	import fsab_pkg::*;

	logic [DATA_W:0]          lsl_w;
	logic [DATA_W:0]          lsr_w;
	logic signed [DATA_W:0]   asr_w;
	logic [DATA_W-1:0]        ror_w;
	logic                     amt_zero;
	logic                     amt_lo;
	logic                     amt_32;

	// Extra bit on the far side catches the last bit shifted out.
	assign lsl_w    = {1'b0, value} << amt[4:0];
	assign lsr_w    = {value, 1'b0} >> amt[4:0];
	assign asr_w    = $signed({value, 1'b0}) >>> amt[4:0];
	assign ror_w    = DATA_W'({value, value} >> amt[4:0]);
	assign amt_zero = (amt == '0);
	assign amt_lo   = (amt[AMT_W-1:5] == '0);
	assign amt_32   = (amt == AMT_W'(DATA_W));

	always_comb begin
		res.value = value;
		res.carry = carry_in;
		if (!amt_zero) begin
			case (op)
				OP_LSL: begin
					if (amt_lo) begin
						res.value = lsl_w[DATA_W-1:0];
						res.carry = lsl_w[DATA_W];
					end else begin
						res.value = '0;
						res.carry = amt_32 & value[0];
					end
				end
				OP_LSR: begin
					if (amt_lo) begin
						res.value = lsr_w[DATA_W:1];
						res.carry = lsr_w[0];
					end else begin
						res.value = '0;
						res.carry = amt_32 & value[DATA_W-1];
					end
				end
				OP_ASR: begin
					if (amt_lo) begin
						res.value = asr_w[DATA_W:1];
						res.carry = asr_w[0];
					end else begin
						res.value = {DATA_W{value[DATA_W-1]}};
						res.carry = value[DATA_W-1];
					end
				end
				OP_ROR: begin
					// multiples of 32 leave the value as is
					res.value = ror_w;
					res.carry = ror_w[DATA_W-1];
				end
				default: begin
					res.value = value;
					res.carry = carry_in;
				end
			endcase
		end
	end

endmodule

// ===== hdl/fsab_alu.sv =====
module fsab_alu (
	input  fsab_pkg::alu_op_t             op,
	input  logic [fsab_pkg::DATA_W-1:0]   a,
	input  logic [fsab_pkg::DATA_W-1:0]   b,
	input  fsab_pkg::flags_t              flags_in,
	output fsab_pkg::alu_res_t            res
);
	import fsab_pkg::*;

	shift_res_t         sh;
	logic [DATA_W-1:0]  add_x;
	logic [DATA_W-1:0]  add_y;
	logic               add_cin;
	logic [DATA_W:0]    sum_w;
	logic [DATA_W-1:0]  sum;
	logic               sum_v;
	logic [DATA_W-1:0]  prod;
	logic [DATA_W-1:0]  r;

	fsab_shift u_shift (
		.op       (op),
		.value    (a),
		.amt      (b[AMT_W-1:0]),
		.carry_in (flags_in.c),
		.res      (sh)
	);

	// Operand select for the single adder.
	always_comb begin
		add_x   = a;
		add_y   = b;
		add_cin = 1'b0;
		case (op)
			OP_ADC: begin
				add_cin = flags_in.c;
			end
			OP_SBC: begin
				add_y   = ~b;
				add_cin = flags_in.c;
			end
			OP_NEG: begin
				add_x   = '0;
				add_y   = ~b;
				add_cin = 1'b1;
			end
			OP_CMP: begin
				add_y   = ~b;
				add_cin = 1'b1;
			end
			default: begin
				add_cin = 1'b0;
			end
		endcase
	end

	assign sum_w = {1'b0, add_x} + {1'b0, add_y} + {{DATA_W{1'b0}}, add_cin};
	assign sum   = sum_w[DATA_W-1:0];
	assign sum_v = ~(add_x[DATA_W-1] ^ add_y[DATA_W-1]) & (add_x[DATA_W-1] ^ sum[DATA_W-1]);
	assign prod  = a * b;

	always_comb begin
		res.flags = flags_in;
		r         = '0;
		case (op)
			OP_AND, OP_TST: r = a & b;
			OP_EOR:         r = a ^ b;
			OP_ORR:         r = a | b;
			OP_BIC:         r = a & ~b;
			OP_MVN:         r = ~b;
			OP_MUL:         r = prod;
			OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin
				r           = sh.value;
				res.flags.c = sh.carry;
			end
			OP_ADC, OP_SBC, OP_NEG, OP_CMP, OP_CMN: begin
				r           = sum;
				res.flags.c = sum_w[DATA_W];
				res.flags.v = sum_v;
			end
			default: r = '0;
		endcase
		res.flags.n    = r[DATA_W-1];
		res.flags.z    = (r == '0);
		res.result     = r;
		res.write_back = !(op inside {OP_TST, OP_CMP, OP_CMN});
	end

endmodule

// ===== hdl/flag_setting_alu_barrel_shift_core.sv =====
// Flag-setting ALU with barrel shifter.
//
// Input stream (s_tvalid/s_tready/s_tdata) carries one request: a 4-bit
// operation, the destination's old value and the source value. The low
// byte of the source is the shift amount for LSL, LSR, ASR and ROR.
// Output stream (m_tvalid/m_tready/m_tdata) carries one result per request:
// the 32-bit value, the write-back strobe and the N, Z, C, V flags.
//
// A request accepted into the stage-1 register moves on into the output
// register, and so onto m_tdata, when that register is free or draining.
// Throughput: one request per clock while m_tready stays high. The N/Z/C/V
// register feeds the ALU together with the request held in the stage-1
// register, so the flag loop runs through the stage-1 adder or multiplier.
//
// Reset clears both stage valid bits and all four flags. When the receiver
// stalls, the result holds in the output register and one more request
// may wait in stage 1; s_tready drops only once both are full and the
// receiver still holds off.
module flag_setting_alu_barrel_shift_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [3:0] action, [35:4] dest_value, [67:36] src_value, [71:68] zero
	input  logic [fsab_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] result, [32] write_back, [33] flag_n, [34] flag_z,
	// [35] flag_c, [36] flag_v, [39:37] zero
	output logic [fsab_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import fsab_pkg::*;

	logic               valid_s1;
	alu_op_t            action_s1;
	logic [DATA_W-1:0]  dest_s1;
	logic [DATA_W-1:0]  src_s1;
	logic               valid_s2;
	alu_res_t           res_s2;
	flags_t             flags_q;
	alu_res_t           alu_res;
	logic               adv_s2;
	logic               move_s1;

	// Output register is free or draining this cycle.
	assign adv_s2   = !valid_s2 || m_tready;
	assign move_s1  = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	fsab_alu u_alu (
		.op       (action_s1),
		.a        (dest_s1),
		.b        (src_s1),
		.flags_in (flags_q),
		.res      (alu_res)
	);

	// Control state: stage valids and the architectural flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			// Commit flags as the result leaves stage 1.
			if (move_s1) begin
				flags_q <= alu_res.flags;
			end
		end
	end

	// Payload: capture on accept, advance on move, hold otherwise.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= alu_op_t'(s_tdata[3:0]);
			dest_s1   <= s_tdata[4 +: DATA_W];
			src_s1    <= s_tdata[4+DATA_W +: DATA_W];
		end
		if (move_s1) begin
			res_s2 <= alu_res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, res_s2.flags.v, res_s2.flags.c, res_s2.flags.z,
		res_s2.flags.n, res_s2.write_back, res_s2.result};

endmodule

// ===== hdl/fsab_checker.sv =====
`include "flag_setting_alu_barrel_shift_core_defines.svh"

module fsab_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [fsab_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import fsab_pkg::*;

	logic nz_ok;

	// N is the sign of the value, Z marks an all-zero value.
	assign nz_ok = (m_tdata[34] == (m_tdata[DATA_W-1:0] == '0)) &&
		(m_tdata[33] == m_tdata[DATA_W-1]);

	// A stalled result stays put.
	`FSAB_ASSERT_NEXT(a_hold_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// A draining output always leaves room for a new request.
	`FSAB_ASSERT_IMPL(a_ready_when_drain, m_tready, s_tready)

	// N and Z always follow the reported value.
	`FSAB_ASSERT_IMPL(a_nz_match, m_tvalid, nz_ok)

	// A fresh result stems from a request that was accepted and then held in stage 1.
	`FSAB_ASSERT_IMPL(a_rose_has_src, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind flag_setting_alu_barrel_shift_core fsab_checker u_fsab_checker (.*);

// ===== test/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fsab_pkg::*;

	// Stop the run when no request moves on either side for this many cycles.
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 550;
	localparam int DIRECTED_ROWS = 25;
	// Long receiver hold-off: far more than the two slots the block can buffer.
	localparam int HOLD_CYCLES   = 80;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	flag_setting_alu_barrel_shift_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// One directed row: the request, and a hand-typed result where one is given.
	typedef struct packed {
		alu_op_t     op;
		logic [31:0] dest;
		logic [31:0] src;
		logic        typed;
		alu_res_t    want;
	} plan_row_t;

	plan_row_t directed_plan [DIRECTED_ROWS];

	// Flag register as the block should hold it after every accepted request.
	flags_t   cur_flags;
	alu_res_t alu_results_q [$];

	bit quiet;          // set for the tail of the run: no idling on either side
	bit long_hold_req;  // ask the receiver for one long hold-off
	int requests_sent;
	int results_checked;
	int mismatches;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Barrel shifter with the carry rules for zero, 32 and larger amounts.
	// A zero amount passes the value through and keeps the carry.
	function automatic shift_res_t barrel_shift(alu_op_t op, logic [31:0] v,
			logic [7:0] amt, logic cin);
		shift_res_t s;
		int         n;
		logic [4:0] k;
		s.value = v;
		s.carry = cin;
		n = amt;
		k = amt[4:0];
		if (n != 0) begin
			case (op)
				OP_LSL: begin
					if (n < 32) begin
						s.value = v << n;
						s.carry = v[32 - n];
					end else begin
						s.value = '0;
						s.carry = (n == 32) ? v[0] : 1'b0;
					end
				end
				OP_LSR: begin
					if (n < 32) begin
						s.value = v >> n;
						s.carry = v[n - 1];
					end else begin
						s.value = '0;
						s.carry = (n == 32) ? v[31] : 1'b0;
					end
				end
				OP_ASR: begin
					if (n < 32) begin
						s.value = $signed(v) >>> n;
						s.carry = v[n - 1];
					end else begin
						s.value = {32{v[31]}};
						s.carry = v[31];
					end
				end
				OP_ROR: begin
					// a nonzero multiple of 32 leaves the value alone but still sets C
					if (k != 5'd0)
						s.value = (v >> k) | (v << (32 - k));
					s.carry = s.value[31];
				end
				default: ;
			endcase
		end
		return s;
	endfunction

	// Work out one result and advance the flag register.
	task automatic execute_alu(input alu_op_t op, input logic [31:0] a,
			input logic [31:0] b, output alu_res_t res);
		logic [31:0] r;
		logic [31:0] x;
		logic [31:0] y;
		logic        cin;
		logic        use_adder;
		logic [32:0] wide;
		shift_res_t  sh;
		r = '0;
		x = a;
		y = b;
		cin = 1'b0;
		use_adder = 1'b0;
		res.write_back = 1'b1;
		case (op)
			OP_AND: r = a & b;
			OP_EOR: r = a ^ b;
			OP_ORR: r = a | b;
			OP_BIC: r = a & ~b;
			OP_MVN: r = ~b;
			OP_MUL: r = a * b;
			OP_TST: begin
				r = a & b;
				res.write_back = 1'b0;
			end
			OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin
				sh = barrel_shift(op, a, b[7:0], cur_flags.c);
				r = sh.value;
				cur_flags.c = sh.carry;
			end
			OP_ADC: begin
				use_adder = 1'b1;
				cin = cur_flags.c;
			end
			OP_SBC: begin
				use_adder = 1'b1;
				y = ~b;
				cin = cur_flags.c;
			end
			OP_NEG: begin
				use_adder = 1'b1;
				x = '0;
				y = ~b;
				cin = 1'b1;
			end
			OP_CMP: begin
				use_adder = 1'b1;
				y = ~b;
				cin = 1'b1;
				res.write_back = 1'b0;
			end
			OP_CMN: begin
				use_adder = 1'b1;
				res.write_back = 1'b0;
			end
			default: ;
		endcase
		// subtraction is a + ~b + carry; C is carry out, not borrow
		if (use_adder) begin
			wide = {1'b0, x} + {1'b0, y} + {32'd0, cin};
			r = wide[31:0];
			cur_flags.c = wide[32];
			cur_flags.v = ~(x[31] ^ y[31]) & (x[31] ^ r[31]);
		end
		cur_flags.n = r[31];
		cur_flags.z = (r == 32'd0);
		res.result = r;
		res.flags = cur_flags;
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'($urandom_range(0, 255));
			default: return $urandom;
		endcase
	endfunction

	// Favor the shift amounts that take the special carry paths.
	function automatic logic [7:0] pick_amount();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd32;
			2: return 8'($urandom_range(1, 7) * 32);
			3: return 8'($urandom_range(33, 255));
			default: return 8'($urandom_range(1, 31));
		endcase
	endfunction

	// Offer one request and hold it until accepted; leave tvalid high so a
	// back-to-back request needs no second assignment in the same step.
	task automatic offer_request(input alu_op_t op, input logic [31:0] a,
			input logic [31:0] b, input logic typed, input alu_res_t typed_res);
		alu_res_t predicted;
		s_tdata <= {4'b0000, b, a, op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		execute_alu(op, a, b, predicted);
		alu_results_q.push_back(typed ? typed_res : predicted);
		requests_sent++;
	endtask

	// Drop tvalid for a random burst now and then.
	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Stimulus: directed table, then random requests in phases.
	initial begin
		alu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cur_flags = '0;
		quiet = 1'b0;
		long_hold_req = 1'b0;
		requests_sent = 0;
		results_checked = 0;
		mismatches = 0;

		// Typed rows hold {result, write_back, NZCV}; others use the predictor.
		directed_plan = '{
			'{OP_AND, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 4'b0100}},
			'{OP_MVN, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 4'b1000}},
			'{OP_CMP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 4'b0110}},
			'{OP_CMN, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, '{32'h8000_0000, 1'b0, 4'b1001}},
			'{OP_ADC, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'h0000_0000, 1'b1, 4'b0110}},
			'{OP_SBC, 32'h0000_0000, 32'h0000_0001, 1'b0, '0},
			'{OP_NEG, 32'h0000_0000, 32'h8000_0000, 1'b0, '0},
			'{OP_NEG, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
			'{OP_EOR, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0, '0},
			'{OP_ORR, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
			'{OP_BIC, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 1'b0, '0},
			'{OP_TST, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '0},
			'{OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
			// zero amount with high source bits set: value and C pass through
			'{OP_LSL, 32'h8000_0001, 32'hFFFF_FF00, 1'b0, '0},
			'{OP_LSL, 32'h8000_0001, 32'h0000_001F, 1'b0, '0},
			'{OP_LSL, 32'h8000_0001, 32'h0000_0020, 1'b0, '0},
			'{OP_LSL, 32'hFFFF_FFFF, 32'h0000_0021, 1'b0, '0},
			'{OP_LSR, 32'h8000_0000, 32'h0000_0020, 1'b0, '0},
			'{OP_LSR, 32'hFFFF_FFFF, 32'h0000_00FF, 1'b0, '0},
			'{OP_ASR, 32'h8000_0000, 32'h0000_0020, 1'b0, '0},
			'{OP_ASR, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, '0},
			'{OP_ROR, 32'h8000_0001, 32'h0000_0040, 1'b0, '0},
			'{OP_ROR, 32'h1234_5678, 32'h0000_0004, 1'b0, '0},
			'{OP_ADC, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
			'{OP_ROR, 32'h0000_0000, 32'h0000_0020, 1'b0, '0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			offer_request(directed_plan[i].op, directed_plan[i].dest, directed_plan[i].src,
				directed_plan[i].typed, directed_plan[i].want);
			sender_gap();
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// Stall the output long enough to fill both stages and block the input.
			if (i == 150)
				long_hold_req = 1'b1;
			// Pause the sender until the pipeline has drained completely.
			if (i == 300) begin
				while (alu_results_q.size() != 0) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
				end
			end
			if (i == 450)
				quiet = 1'b1;
			op = alu_op_t'($urandom_range(0, 15));
			a = pick_operand();
			b = pick_operand();
			if (op == OP_LSL || op == OP_LSR || op == OP_ASR || op == OP_ROR)
				b[7:0] = pick_amount();
			offer_request(op, a, b, 1'b0, '0);
			sender_gap();
		end

		s_tvalid <= 1'b0;
		while (alu_results_q.size() != 0) @(posedge clk);
		// Keep the clock running so that any stray result can still show up.
		repeat (8) @(posedge clk);

		$display("Covered %0d requests: every operation, shift amounts 0, 32 and above,",
			requests_sent);
		$display("carry chains and backpressure; %0d results checked, %0d mismatches.",
			results_checked, mismatches);
		if (mismatches == 0 && alu_results_q.size() == 0) begin
			$display("** flag_setting_alu_barrel_shift_core: PASSED **");
		end else begin
			$display("** flag_setting_alu_barrel_shift_core: FAILED **");
		end
		$finish;
	end

	// Result side: check every accepted result, then drive tready for the next edge.
	initial begin : result_sink
		alu_res_t got;
		alu_res_t want;
		int       stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.result = m_tdata[31:0];
				got.write_back = m_tdata[32];
				got.flags.n = m_tdata[33];
				got.flags.z = m_tdata[34];
				got.flags.c = m_tdata[35];
				got.flags.v = m_tdata[36];
				if (alu_results_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t: unexpected result %h wb=%b nzcv=%b", $realtime,
							got.result, got.write_back, got.flags);
				end else begin
					want = alu_results_q.pop_front();
					results_checked++;
					if (got.result !== want.result || got.write_back !== want.write_back ||
							got.flags !== want.flags) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%t: mismatch exp %h wb=%b nzcv=%b, got %h wb=%b nzcv=%b",
								$realtime, want.result, want.write_back, want.flags,
								got.result, got.write_back, got.flags);
					end
				end
			end
			if (long_hold_req) begin
				stall_left = HOLD_CYCLES;
				long_hold_req = 1'b0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: count cycles in which no request or result moves.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
					STALL_LIMIT, alu_results_q.size());
				$display("** flag_setting_alu_barrel_shift_core: FAILED **");
				$finish;
			end
		end
	end

endmodule
